FILE: hdl/psraa_pkg.sv
// Shared types and constants for the per-sensor running average alarm.
package psraa_pkg;

  localparam int MAX_SENSORS_DEF = 64;
  localparam int WINDOW_LEN_DEF  = 5;
  localparam int DATA_W          = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = 1;
  localparam int QCNT_W          = 2;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  // Request kinds
  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_MEASURE  = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_MAX_TEMP = 1'b0;
  localparam logic REG_MIN_TEMP = 1'b1;

  typedef enum logic [2:0] {
    ST_NORMAL     = 3'd0,
    ST_HOT        = 3'd1,
    ST_COLD       = 3'd2,
    ST_UNKNOWN    = 3'd3,
    ST_ALLZERO    = 3'd4,
    ST_REGISTERED = 3'd5,
    ST_FULL       = 3'd6
  } status_t;

  typedef struct packed {
    logic                     req_type;
    logic [DATA_W-1:0]        sensor_id;
    logic [DATA_W-1:0]        room_id;
    logic signed [DATA_W-1:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]        out_sensor;
    logic [DATA_W-1:0]        out_room;
    logic signed [DATA_W-1:0] average;
    status_t                  status;
  } out_item_t;

  // Head of the request queue as seen by the back end
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;

endpackage

FILE: hdl/per_sensor_running_average_alarm.sv
// Per-sensor running average alarm, top level.
//
// Requests arrive on in_valid/in_stall/in_item and one result per request
// leaves on out_valid/out_stall/out_item; a transaction completes on a clock
// edge with valid high and stall low. A register request (req_type 0) appends
// the sensor and its room and clears its sample window; a measurement looks
// the sensor up, shifts the sample in and reports the mean of the nonzero
// samples against max_temp/min_temp, written over the APB port (0x0, 0x4).
// A two-entry queue sits ahead of a sequencer that handles one item at once.
// A register request's time is set by the window clear. A measurement scans
// the table for the matching entry, one a cycle through the single table
// read port, then reads and shifts the window and divides; the bit-serial
// divider yields one quotient bit a cycle. The next queued item is taken in
// the cycle after each result is registered. Reset (synchronous, rst high)
// empties the table and queue and restores the thresholds; no clearing pass
// is needed. While out_stall is high the result holds; the sequencer waits
// and the queue stalls its input once full.
module per_sensor_running_average_alarm #(
  parameter int MAX_SENSORS = psraa_pkg::MAX_SENSORS_DEF,
  parameter int WINDOW_LEN  = psraa_pkg::WINDOW_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  psraa_pkg::in_item_t               in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output psraa_pkg::out_item_t              out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psraa_pkg::PADDR_W-1:0]     paddr,
  input  logic [psraa_pkg::PDATA_W-1:0]     pwdata,
  output logic [psraa_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);
  import psraa_pkg::*;

  queue_head_t              head;
  logic                     pop;
  logic signed [DATA_W-1:0] max_temp;
  logic signed [DATA_W-1:0] min_temp;
  logic                     cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_temp <= 16'sh7FFF;
      min_temp <= 16'sh8000;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_MAX_TEMP: max_temp <= pwdata[DATA_W-1:0];
        REG_MIN_TEMP: min_temp <= pwdata[DATA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_MIN_TEMP) ? {16'b0, min_temp} : {16'b0, max_temp};

  psraa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  psraa_back #(
    .MAX_SENSORS (MAX_SENSORS),
    .WINDOW_LEN  (WINDOW_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .max_temp  (max_temp),
    .min_temp  (min_temp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: hdl/psraa_front.sv
// Front end: accepts requests into a short queue ahead of the sequencer.
module psraa_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  psraa_pkg::in_item_t    in_item,
  output psraa_pkg::queue_head_t head,
  input  logic                   pop
);
  import psraa_pkg::*;

  in_item_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;
  logic                push;
  logic                take;

  assign in_stall = (fill == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign take     = pop && (fill != '0);

  assign head.valid = (fill != '0);
  assign head.item  = entries[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (take) rd_ptr <= rd_ptr + 1'b1;
      if (push && !take)      fill <= fill + 1'b1;
      else if (take && !push) fill <= fill - 1'b1;
    end
  end

endmodule

FILE: hdl/psraa_div.sv
// Signed-by-unsigned restoring divider, one quotient bit a cycle, truncating.
module psraa_div #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quo
);
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  mag;
  logic [NUM_W-1:0]  q;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_q;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              neg;
  logic [DEN_W:0]    rem_sh;
  logic              fits;

  assign rem_sh = {rem, mag[NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_q});
  assign quo    = neg ? -$signed(q) : $signed(q);

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mag   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      neg   <= num[NUM_W-1];
      den_q <= den;
      rem   <= '0;
      q     <= '0;
    end else if (busy) begin
      mag <= {mag[NUM_W-2:0], 1'b0};
      q   <= {q[NUM_W-2:0], fits};
      rem <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
    end
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= '0;
      end else if (busy) begin
        steps <= steps + 1'b1;
        if (steps == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/psraa_back.sv
// Back end: sensor table, sample windows, averaging sequencer and result register.
module psraa_back #(
  parameter int MAX_SENSORS = psraa_pkg::MAX_SENSORS_DEF,
  parameter int WINDOW_LEN  = psraa_pkg::WINDOW_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  psraa_pkg::queue_head_t               head,
  output logic                                 pop,
  input  logic signed [psraa_pkg::DATA_W-1:0]  max_temp,
  input  logic signed [psraa_pkg::DATA_W-1:0]  min_temp,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output psraa_pkg::out_item_t                 out_item
);
  import psraa_pkg::*;

  localparam int IW    = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CNTW  = $clog2(MAX_SENSORS + 1);
  localparam int WDEP  = MAX_SENSORS * WINDOW_LEN;
  localparam int WAW   = (WDEP > 1) ? $clog2(WDEP) : 1;
  localparam int JW    = $clog2(WINDOW_LEN + 1);
  localparam int SUMW  = DATA_W + JW;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CLEAR  = 9'b000000010,
    S_SEARCH = 9'b000000100,
    S_WRD    = 9'b000001000,
    S_WWR    = 9'b000010000,
    S_LAST   = 9'b000100000,
    S_CHK    = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_RESULT = 9'b100000000
  } state_t;

  state_t state;

  // Memories
  logic [DATA_W-1:0] sensor_mem [MAX_SENSORS];
  logic [DATA_W-1:0] room_mem   [MAX_SENSORS];
  logic [DATA_W-1:0] win_mem    [WDEP];

  in_item_t           cur;
  logic [CNTW-1:0]    count;
  logic [WAW-1:0]     fill_base;
  logic [WAW-1:0]     base;
  logic [CNTW-1:0]    scan_idx;
  logic [WAW-1:0]     scan_base;
  logic               cmp_valid;
  logic [IW-1:0]      cmp_idx;
  logic [WAW-1:0]     cmp_base;
  logic [JW-1:0]      j;
  logic signed [SUMW-1:0] sum;
  logic [JW-1:0]      nz;
  logic [DATA_W-1:0]  id_rd;
  logic [DATA_W-1:0]  room_rd;
  logic [DATA_W-1:0]  win_rd;
  out_item_t          res;

  logic               tbl_we;
  logic               id_re;
  logic               win_we;
  logic [WAW-1:0]     win_waddr;
  logic [DATA_W-1:0]  win_wdata;
  logic [WAW-1:0]     win_raddr;
  logic               found;
  logic               div_start;
  logic               div_done;
  logic signed [SUMW-1:0] div_quo;
  logic signed [DATA_W-1:0] avg;
  logic               out_free;

  assign out_free = !out_valid || !out_stall;
  assign found    = cmp_valid && (id_rd == cur.sensor_id);
  assign pop      = (state == S_IDLE) && head.valid;
  assign tbl_we   = pop && (head.item.req_type == REQ_REGISTER)
                    && (count != CNTW'(MAX_SENSORS));
  assign id_re    = (state == S_SEARCH) && !found && (scan_idx < count);
  assign avg      = div_quo[DATA_W-1:0];

  // Window port control
  always_comb begin
    win_we    = 1'b0;
    win_waddr = base + WAW'(j);
    win_wdata = '0;
    win_raddr = base + WAW'(j);
    case (state)
      S_CLEAR: begin
        win_we = 1'b1;
      end
      S_WWR: begin
        win_we    = 1'b1;
        win_waddr = base + WAW'(j - JW'(1));
        win_wdata = win_rd;
      end
      S_LAST: begin
        win_we    = 1'b1;
        win_waddr = base + WAW'(WINDOW_LEN - 1);
        win_wdata = cur.temperature;
      end
      default: begin
      end
    endcase
  end

  // Table memories
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      sensor_mem[count[IW-1:0]] <= head.item.sensor_id;
      room_mem[count[IW-1:0]]   <= head.item.room_id;
    end
    if (id_re) id_rd <= sensor_mem[scan_idx[IW-1:0]];
    room_rd <= room_mem[cmp_idx];
  end

  // Window memory
  always_ff @(posedge clk) begin
    if (win_we) win_mem[win_waddr] <= win_wdata;
    win_rd <= win_mem[win_raddr];
  end

  psraa_div #(
    .NUM_W (SUMW),
    .DEN_W (JW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum),
    .den   (nz),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign div_start = (state == S_CHK) && (nz != '0);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      fill_base <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Result taken; the result state sets it again when it has a new one
      if (!out_stall && (state != S_RESULT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            cur <= head.item;
            res.out_sensor <= head.item.sensor_id;
            res.out_room   <= head.item.room_id;
            res.average    <= '0;
            if (head.item.req_type == REQ_REGISTER) begin
              if (count == CNTW'(MAX_SENSORS)) begin
                res.status <= ST_FULL;
                state      <= S_RESULT;
              end else begin
                base  <= fill_base;
                j     <= '0;
                state <= S_CLEAR;
              end
            end else begin
              scan_idx  <= '0;
              scan_base <= '0;
              cmp_valid <= 1'b0;
              state     <= S_SEARCH;
            end
          end
        end
        S_CLEAR: begin
          j <= j + 1'b1;
          if (j == JW'(WINDOW_LEN - 1)) begin
            count      <= count + 1'b1;
            fill_base  <= fill_base + WAW'(WINDOW_LEN);
            res.status <= ST_REGISTERED;
            state      <= S_RESULT;
          end
        end
        S_SEARCH: begin
          if (found) begin
            base  <= cmp_base;
            j     <= JW'(1);
            sum   <= '0;
            nz    <= '0;
            state <= (WINDOW_LEN > 1) ? S_WRD : S_LAST;
          end else if (scan_idx < count) begin
            cmp_idx   <= scan_idx[IW-1:0];
            cmp_base  <= scan_base;
            scan_idx  <= scan_idx + 1'b1;
            scan_base <= scan_base + WAW'(WINDOW_LEN);
            cmp_valid <= 1'b1;
          end else if (cmp_valid) begin
            cmp_valid <= 1'b0;
          end else begin
            res.out_room <= '0;
            res.status   <= ST_UNKNOWN;
            state        <= S_RESULT;
          end
        end
        S_WRD: begin
          state <= S_WWR;
        end
        S_WWR: begin
          sum <= sum + {{JW{win_rd[DATA_W-1]}}, win_rd};
          if (win_rd != '0) nz <= nz + 1'b1;
          j <= j + 1'b1;
          state <= (j == JW'(WINDOW_LEN - 1)) ? S_LAST : S_WRD;
        end
        S_LAST: begin
          sum <= sum + {{JW{cur.temperature[DATA_W-1]}}, cur.temperature};
          if (cur.temperature != '0) nz <= nz + 1'b1;
          state <= S_CHK;
        end
        S_CHK: begin
          res.out_room <= room_rd;
          if (nz == '0) begin
            res.status <= ST_ALLZERO;
            state      <= S_RESULT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res.average <= avg;
            if (avg > max_temp)      res.status <= ST_HOT;
            else if (avg < min_temp) res.status <= ST_COLD;
            else                     res.status <= ST_NORMAL;
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_item  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/psraa_checker.sv
// Port-level checks for the running average alarm, bound to the top level.
module psraa_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input psraa_pkg::out_item_t out_item
);
  import psraa_pkg::*;

  // Nothing presented straight after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Non-average results carry a zero average
  a_zero_avg: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == ST_REGISTERED || out_item.status == ST_FULL ||
                  out_item.status == ST_UNKNOWN || out_item.status == ST_ALLZERO)
    |-> out_item.average == '0)
    else $error("average not zero");

  // Unknown sensor has no room
  a_unknown_room: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_UNKNOWN |-> out_item.out_room == '0)
    else $error("unknown sensor with a room");

  // Status code in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.status <= ST_FULL)
    else $error("status out of range");

endmodule

bind per_sensor_running_average_alarm psraa_checker u_psraa_checker (.*);

FILE: sim/tb_per_sensor_running_average_alarm.sv
// Testbench for the per-sensor running average alarm: table-driven and random checks.
`timescale 1ns / 1ps

module tb_per_sensor_running_average_alarm;
  import psraa_pkg::*;

  localparam int N_SENS    = MAX_SENSORS_DEF;
  localparam int WIN       = WINDOW_LEN_DEF;
  localparam int N_RANDOM  = 600;
  localparam int CYC_LIMIT = 400000;
  localparam int DRAIN_CYC = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  per_sensor_running_average_alarm i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [15:0]        pred_sid [N_SENS];
  logic [15:0]        pred_room [N_SENS];
  logic signed [15:0] pred_win [N_SENS][WIN];
  int                 pred_count;
  logic signed [15:0] thr_hot;
  logic signed [15:0] thr_cold;

  out_item_t expected_q[$];
  int  errors = 0;
  int  cycles = 0;
  bit  hold_mode = 1'b0;
  bit  calm = 1'b0;
  bit  long_hold = 1'b0;

  // Average/alarm prediction for one request
  function automatic out_item_t predict_alarm(in_item_t rq);
    out_item_t r;
    int slot, nz, sum, avg;
    r = '0;
    r.out_sensor = rq.sensor_id;
    if (rq.req_type == REQ_REGISTER) begin
      r.out_room = rq.room_id;
      if (pred_count >= N_SENS) begin
        r.status = ST_FULL;
      end else begin
        pred_sid[pred_count] = rq.sensor_id;
        pred_room[pred_count] = rq.room_id;
        for (int i = 0; i < WIN; i++) pred_win[pred_count][i] = '0;
        pred_count++;
        r.status = ST_REGISTERED;
      end
      return r;
    end
    slot = -1;
    for (int i = 0; i < pred_count; i++)
      if (slot < 0 && pred_sid[i] == rq.sensor_id) slot = i;
    if (slot < 0) begin
      r.status = ST_UNKNOWN;
      return r;
    end
    for (int i = 0; i < WIN - 1; i++) pred_win[slot][i] = pred_win[slot][i+1];
    pred_win[slot][WIN-1] = rq.temperature;
    r.out_room = pred_room[slot];
    sum = 0;
    nz = 0;
    for (int i = 0; i < WIN; i++) begin
      sum += int'(pred_win[slot][i]);
      if (pred_win[slot][i] != 0) nz++;
    end
    if (nz == 0) begin
      r.status = ST_ALLZERO;
      return r;
    end
    avg = sum / nz;
    r.average = avg[15:0];
    if (avg > int'(thr_hot)) r.status = ST_HOT;
    else if (avg < int'(thr_cold)) r.status = ST_COLD;
    else r.status = ST_NORMAL;
    return r;
  endfunction

  // Random idling decision
  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < 33);
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: stall generation and result checking
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        errors <= errors + 1;
      end else if (out_item !== expected_q[0]) begin
        $display("%0t: expected %p actual %p", $time, expected_q[0], out_item);
        errors <= errors + 1;
        void'(expected_q.pop_front());
      end else begin
        void'(expected_q.pop_front());
      end
    end
    out_stall <= long_hold ? 1'b1 : idle_now();
  end

  // Long receiver hold-off, counted here
  initial begin
    wait (hold_mode);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (600) @(posedge clk);
    long_hold = 1'b0;
  end

  task automatic apb_write(input logic idx, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {{16{val[15]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_MAX_TEMP) thr_hot = val; else thr_cold = val;
  endtask

  // Send one transaction, queueing its prediction at acceptance
  task automatic send_req(input in_item_t rq, input bit chk, input out_item_t want);
    out_item_t p;
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= rq;
    do @(posedge clk); while (in_stall);
    p = predict_alarm(rq);
    if (chk && p !== want) begin
      $display("%0t: expected %p actual %p (table)", $time, want, p);
      errors++;
    end
    expected_q.push_back(p);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic in_item_t mk(logic k, logic [15:0] s, logic [15:0] r,
                                  logic [15:0] t);
    in_item_t x;
    x.req_type = k; x.sensor_id = s; x.room_id = r; x.temperature = t;
    return x;
  endfunction

  function automatic out_item_t mko(logic [15:0] s, logic [15:0] r,
                                    logic [15:0] a, status_t st);
    out_item_t x;
    x.out_sensor = s; x.out_room = r; x.average = a; x.status = st;
    return x;
  endfunction

  // Directed table
  typedef struct {
    in_item_t  rq;
    bit        chk;
    out_item_t want;
  } row_t;

  row_t rows[$];
  logic [15:0] known[$];
  in_item_t rq;

  initial begin
    pred_count = 0;
    thr_hot = 16'sh7FFF;
    thr_cold = 16'sh8000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    rows.push_back('{mk(REQ_MEASURE, 16'h1234, 16'h0, 16'h0100), 1'b1,
                     mko(16'h1234, 16'h0, 16'h0, ST_UNKNOWN)});
    rows.push_back('{mk(REQ_REGISTER, 16'h0000, 16'hFFFF, 16'h0), 1'b1,
                     mko(16'h0000, 16'hFFFF, 16'h0, ST_REGISTERED)});
    rows.push_back('{mk(REQ_REGISTER, 16'hFFFF, 16'h0000, 16'hFFFF), 1'b1,
                     mko(16'hFFFF, 16'h0000, 16'h0, ST_REGISTERED)});
    rows.push_back('{mk(REQ_REGISTER, 16'h0000, 16'h5555, 16'h0), 1'b1,
                     mko(16'h0000, 16'h5555, 16'h0, ST_REGISTERED)});
    rows.push_back('{mk(REQ_MEASURE, 16'h0000, 16'h0, 16'h0000), 1'b1,
                     mko(16'h0000, 16'hFFFF, 16'h0, ST_ALLZERO)});
    rows.push_back('{mk(REQ_MEASURE, 16'h0000, 16'hAAAA, 16'h7FFF), 1'b1,
                     mko(16'h0000, 16'hFFFF, 16'h7FFF, ST_NORMAL)});
    rows.push_back('{mk(REQ_MEASURE, 16'h0000, 16'h0, 16'h8000), 1'b0, '0});
    rows.push_back('{mk(REQ_MEASURE, 16'hFFFF, 16'h0, 16'h8000), 1'b1,
                     mko(16'hFFFF, 16'h0000, 16'h8000, ST_NORMAL)});
    rows.push_back('{mk(REQ_MEASURE, 16'hFFFF, 16'h0, 16'h8000), 1'b0, '0});
    for (int i = 0; i < 6; i++)
      rows.push_back('{mk(REQ_MEASURE, 16'hFFFF, 16'h0, 16'h0000), 1'b0, '0});
    foreach (rows[i]) send_req(rows[i].rq, rows[i].chk, rows[i].want);
    wait_idle();

    // Tight thresholds, then inverted ones
    apb_write(REG_MAX_TEMP, 16'h0100);
    apb_write(REG_MIN_TEMP, 16'hFF00);
    send_req(mk(REQ_MEASURE, 16'h0000, 16'h0, 16'h0200), 1'b0, '0);
    send_req(mk(REQ_MEASURE, 16'hFFFF, 16'h0, 16'hF000), 1'b0, '0);
    send_req(mk(REQ_MEASURE, 16'hFFFF, 16'h0, 16'h0080), 1'b0, '0);
    wait_idle();
    apb_write(REG_MAX_TEMP, 16'h8000);
    apb_write(REG_MIN_TEMP, 16'h7FFF);
    send_req(mk(REQ_MEASURE, 16'h0000, 16'h0, 16'h0001), 1'b0, '0);
    send_req(mk(REQ_MEASURE, 16'hFFFF, 16'h0, 16'h0001), 1'b0, '0);
    wait_idle();

    // Random phases with different thresholds; table fills up along the way
    known = '{16'h0000, 16'hFFFF};
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) begin
        apb_write(REG_MAX_TEMP, 16'h7FFF);
        apb_write(REG_MIN_TEMP, 16'h8000);
      end else begin
        apb_write(REG_MAX_TEMP, 16'($urandom_range(0, 16'h0800)));
        apb_write(REG_MIN_TEMP, 16'(-$urandom_range(0, 16'h0800)));
      end
      calm = (ph == 2);
      if (ph == 3) hold_mode = 1'b1;
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        int sel;
        sel = $urandom_range(0, 99);
        rq = mk(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 16'($urandom));
        if (sel < 15) begin
          rq.req_type = REQ_REGISTER;
          if ($urandom_range(0, 3) == 0 && known.size() > 0)
            rq.sensor_id = known[$urandom_range(0, known.size() - 1)];
          known.push_back(rq.sensor_id);
        end else if (sel < 85) begin
          rq.req_type = REQ_MEASURE;
          rq.sensor_id = known[$urandom_range(0, known.size() - 1)];
          if ($urandom_range(0, 4) == 0) rq.temperature = '0;
          else if ($urandom_range(0, 1)) rq.temperature = 16'($signed($urandom_range(0, 4096)) - 2048);
        end else if (sel < 90) begin
          rq.req_type = REQ_MEASURE;
        end
        send_req(rq, 1'b0, '0);
      end
      wait_idle();
    end

    calm = 1'b0;
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/psraa_pkg.sv
hdl/psraa_front.sv
hdl/psraa_div.sv
hdl/psraa_back.sv
hdl/per_sensor_running_average_alarm.sv
hdl/psraa_checker.sv
sim/tb_per_sensor_running_average_alarm.sv
